// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// label, clock, active-low reset, property, message
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// same, but checked during reset as well
`define ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rstn, prop, msg)
`define ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

// ===== rtl/core/ccsync_pkg.sv =====
// ----------------------------------------------------------------------------
// ccsync_pkg
// Shared types and constants of the crank/cam sync detector.
// ----------------------------------------------------------------------------
package ccsync_pkg;

	// event codes
	localparam logic [2:0] REQ_CRANK_TOOTH  = 3'd0;
	localparam logic [2:0] REQ_LONG_TOOTH   = 3'd1;
	localparam logic [2:0] REQ_INTAKE_EDGE  = 3'd2;
	localparam logic [2:0] REQ_EXHAUST_EDGE = 3'd3;
	localparam logic [2:0] REQ_POS_STATUS   = 3'd4;

	// register indexes
	localparam logic [2:0] CFG_TEETH_PER_TARGET = 3'd0;
	localparam logic [2:0] CFG_GAP_TEETH        = 3'd1;
	localparam logic [2:0] CFG_ANGLE_WINDOW     = 3'd2;
	localparam logic [2:0] CFG_ACCURATE_THRESH  = 3'd3;
	localparam logic [2:0] CFG_COARSE_THRESH    = 3'd4;
	localparam logic [2:0] CFG_INTAKE_REFS      = 3'd5;
	localparam logic [2:0] CFG_EXHAUST_REFS     = 3'd6;

	localparam int REF_SLOTS   = 6;
	localparam int REF_W       = 10;
	localparam int REFS_W      = REF_SLOTS * REF_W;
	localparam int CFG_DATA_W  = REFS_W;

	localparam logic [6:0] TOOTH_SAT    = 7'd70;
	localparam logic [6:0] EDGE_POS_MAX = 7'd120;
	localparam logic [7:0] EDGE_CNT_TOP = 8'd254;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [15:0] cam_angle;
		logic        position_known;
		logic        force_not_synced;
		logic        sync_inhibited;
	} in_word_t;

	typedef struct packed {
		logic [6:0] tooth_count;
		logic       gap_near;
		logic [6:0] edge_position;
		logic [7:0] intake_good_edges;
		logic [7:0] exhaust_good_edges;
		logic       long_tooth_mark;
		logic       accurate_sync;
		logic       coarse_sync;
	} out_word_t;

endpackage

// ===== rtl/core/ccsync_edge_win.sv =====
// ----------------------------------------------------------------------------
// ccsync_edge_win
// Checks a rounded cam edge position against a set of reference angles.
// ----------------------------------------------------------------------------
module ccsync_edge_win #(
	parameter int REF_COUNT = 6
) (
	input  logic [6:0]                   pos,
	input  logic [ccsync_pkg::REFS_W-1:0] refs,
	input  logic [7:0]                   window,
	output logic                         hit
);
	import ccsync_pkg::*;

	logic [REF_W-1:0] target;
	logic [REF_SLOTS-1:0] slot_hit;

	// 6 * pos, at most 720
	assign target = {1'b0, pos, 2'b00} + {2'b00, pos, 1'b0};

	always_comb begin
		logic [REF_W-1:0] ref_a;
		logic [REF_W-1:0] delta;
		slot_hit = '0;
		for (int i = 0; i < REF_SLOTS; i++) begin
			ref_a = refs[i*REF_W +: REF_W];
			delta = (target >= ref_a) ? (target - ref_a) : (ref_a - target);
			if (i < REF_COUNT)
				slot_hit[i] = delta < {2'b00, window};
		end
	end

	assign hit = |slot_hit;

endmodule

// ===== rtl/core/engine_crank_cam_sync_detector_top.sv =====
// ----------------------------------------------------------------------------
// engine_crank_cam_sync_detector_top
// Crank tooth counting, cam edge qualification and engine sync flags.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall/in_data carries one engine event per word
//   (crank tooth, long tooth, intake edge, exhaust edge, position status).
//   Output channel out_valid/out_stall/out_data returns exactly one word per
//   event: the detector state after that event plus the rounded edge position.
//   A word is taken on a rising edge with valid high and stall low.
//   An accepted event passes the input register, then the result register,
//   before out_valid. Throughput: one event per cycle while the receiver does
//   not stall; the only loop is the state update between the two registers.
//   When the receiver stalls, the result register holds; one more event may
//   sit in the input register, after which in_stall rises.
//   Config: wr_en/wr_index/wr_data write one reg per cycle, index 7 ignored;
//   the user must write only while no event is in flight (not enforced).
//   Reset (arst_n low, asynchronous): all state cleared, registers back to
//   their defaults (60 teeth, 2 gap teeth, everything else 0), both channel
//   stages empty. No clearing pass; an event may be sent right after reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module engine_crank_cam_sync_detector_top #(
	parameter int REF_ANGLE_COUNT = 6
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// config write port
	input  logic                             wr_en,
	input  logic [2:0]                       wr_index,
	input  logic [ccsync_pkg::CFG_DATA_W-1:0] wr_data,
	// event channel
	input  logic                             in_valid,
	output logic                             in_stall,
	input  ccsync_pkg::in_word_t             in_data,
	// result channel
	output logic                             out_valid,
	input  logic                             out_stall,
	output ccsync_pkg::out_word_t            out_data
);
	import ccsync_pkg::*;

	// ---------------- configuration registers ----------------
	logic [7:0]        teeth_per_target_q;
	logic [7:0]        gap_teeth_q;
	logic [7:0]        angle_window_q;
	logic [7:0]        acc_thresh_q;
	logic [7:0]        crs_thresh_q;
	logic [REFS_W-1:0] intake_refs_q;
	logic [REFS_W-1:0] exhaust_refs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			teeth_per_target_q <= 8'd60;
			gap_teeth_q        <= 8'd2;
			angle_window_q     <= '0;
			acc_thresh_q       <= '0;
			crs_thresh_q       <= '0;
			intake_refs_q      <= '0;
			exhaust_refs_q     <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_TEETH_PER_TARGET: teeth_per_target_q <= wr_data[7:0];
				CFG_GAP_TEETH:        gap_teeth_q        <= wr_data[7:0];
				CFG_ANGLE_WINDOW:     angle_window_q     <= wr_data[7:0];
				CFG_ACCURATE_THRESH:  acc_thresh_q       <= wr_data[7:0];
				CFG_COARSE_THRESH:    crs_thresh_q       <= wr_data[7:0];
				CFG_INTAKE_REFS:      intake_refs_q      <= wr_data;
				CFG_EXHAUST_REFS:     exhaust_refs_q     <= wr_data;
				default: ;
			endcase
		end
	end

	// ---------------- input stage ----------------
	// The edge position only depends on the raw angle, so it is rounded on the
	// way into the input register: (a + 192) / 384 = ((a + 192) >> 7) / 3,
	// and x / 3 = (x * 683) >> 11 exactly for x < 2048.
	logic [16:0] ang_biased;
	logic [9:0]  ang_div128;
	logic [19:0] ang_prod;
	logic [8:0]  ang_quo;
	logic [6:0]  edge_pos_in;

	assign ang_biased  = {1'b0, in_data.cam_angle} + 17'd192;
	assign ang_div128  = ang_biased[16:7];
	assign ang_prod    = ang_div128 * 10'd683;
	assign ang_quo     = ang_prod[19:11];
	assign edge_pos_in = (ang_quo > {2'b00, EDGE_POS_MAX}) ? EDGE_POS_MAX : ang_quo[6:0];

	logic     valid_s1;
	in_word_t word_s1;
	logic [6:0] edge_pos_s1;
	logic     advance;
	logic     out_valid_q;

	// s1 moves on whenever the result register is empty or being drained
	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			word_s1     <= in_data;
			edge_pos_s1 <= edge_pos_in;
		end
	end

	// ---------------- detector state ----------------
	logic [6:0] teeth_q;
	logic       gap_q;
	logic       clr_next_q;
	logic       long_seen_q;
	logic [7:0] intake_cnt_q;
	logic [7:0] exhaust_cnt_q;
	logic       pos_known_q;
	logic       acc_q;
	logic       crs_q;

	logic [6:0] teeth_n;
	logic       gap_n;
	logic       clr_next_n;
	logic       long_seen_n;
	logic [7:0] intake_cnt_n;
	logic [7:0] exhaust_cnt_n;
	logic       pos_known_n;
	logic       acc_n;
	logic       crs_n;
	logic [6:0] edge_pos_n;

	// window check for the side named by the event
	logic              is_exhaust;
	logic [REFS_W-1:0] side_refs;
	logic              edge_hit;

	assign is_exhaust = (word_s1.req_type == REQ_EXHAUST_EDGE);
	assign side_refs  = is_exhaust ? exhaust_refs_q : intake_refs_q;

	ccsync_edge_win #(
		.REF_COUNT (REF_ANGLE_COUNT)
	) u_edge_win (
		.pos    (edge_pos_s1),
		.refs   (side_refs),
		.window (angle_window_q),
		.hit    (edge_hit)
	);

	// tooth advance; compared before saturation, target ignored when negative
	logic [6:0] teeth_inc;
	logic       gap_match;
	logic [7:0] gap_target;

	assign teeth_inc  = teeth_q + 7'd1;
	assign gap_target = teeth_per_target_q - gap_teeth_q;
	assign gap_match  = (teeth_per_target_q >= gap_teeth_q) &&
	                    ({1'b0, teeth_inc} == gap_target);

	// sync qualification from the current counters
	logic acc_cnt_ok;
	logic crs_cnt_ok;
	logic acc_calc;

	assign acc_cnt_ok = (intake_cnt_q >= acc_thresh_q) || (exhaust_cnt_q >= acc_thresh_q);
	assign crs_cnt_ok = (intake_cnt_q >= crs_thresh_q) || (exhaust_cnt_q >= crs_thresh_q);
	assign acc_calc   = long_seen_q && acc_cnt_ok;

	always_comb begin
		teeth_n       = teeth_q;
		gap_n         = gap_q;
		clr_next_n    = clr_next_q;
		long_seen_n   = long_seen_q;
		intake_cnt_n  = intake_cnt_q;
		exhaust_cnt_n = exhaust_cnt_q;
		pos_known_n   = pos_known_q;
		acc_n         = acc_q;
		crs_n         = crs_q;
		edge_pos_n    = '0;

		case (word_s1.req_type)
			REQ_CRANK_TOOTH: begin
				gap_n = gap_match;
				if (clr_next_q) begin
					teeth_n    = '0;
					clr_next_n = 1'b0;
				end else begin
					teeth_n = (teeth_inc > TOOTH_SAT) ? TOOTH_SAT : teeth_inc;
				end
			end
			REQ_LONG_TOOTH: begin
				clr_next_n  = 1'b1;
				long_seen_n = 1'b1;
			end
			REQ_INTAKE_EDGE, REQ_EXHAUST_EDGE: begin
				edge_pos_n = edge_pos_s1;
				if (edge_hit) begin
					if (is_exhaust)
						exhaust_cnt_n = (exhaust_cnt_q == EDGE_CNT_TOP) ? '0
						              : exhaust_cnt_q + 8'd1;
					else
						intake_cnt_n = (intake_cnt_q == EDGE_CNT_TOP) ? '0
						             : intake_cnt_q + 8'd1;
				end
			end
			REQ_POS_STATUS: begin
				if (word_s1.position_known) begin
					if (!word_s1.force_not_synced && !word_s1.sync_inhibited) begin
						acc_n = acc_calc;
						crs_n = acc_calc || long_seen_q || crs_cnt_ok;
					end
					// first known position: start from a clean slate
					if (!pos_known_q) begin
						acc_n         = 1'b0;
						crs_n         = 1'b0;
						long_seen_n   = 1'b0;
						intake_cnt_n  = '0;
						exhaust_cnt_n = '0;
					end
				end
				pos_known_n = word_s1.position_known;
			end
			default: ;
		endcase
	end

	logic fire;
	assign fire = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			teeth_q       <= '0;
			gap_q         <= 1'b0;
			clr_next_q    <= 1'b0;
			long_seen_q   <= 1'b0;
			intake_cnt_q  <= '0;
			exhaust_cnt_q <= '0;
			pos_known_q   <= 1'b0;
			acc_q         <= 1'b0;
			crs_q         <= 1'b0;
		end else if (fire) begin
			teeth_q       <= teeth_n;
			gap_q         <= gap_n;
			clr_next_q    <= clr_next_n;
			long_seen_q   <= long_seen_n;
			intake_cnt_q  <= intake_cnt_n;
			exhaust_cnt_q <= exhaust_cnt_n;
			pos_known_q   <= pos_known_n;
			acc_q         <= acc_n;
			crs_q         <= crs_n;
		end
	end

	// ---------------- result register ----------------
	out_word_t out_word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_word_q.tooth_count        <= teeth_n;
			out_word_q.gap_near           <= gap_n;
			out_word_q.edge_position      <= edge_pos_n;
			out_word_q.intake_good_edges  <= intake_cnt_n;
			out_word_q.exhaust_good_edges <= exhaust_cnt_n;
			out_word_q.long_tooth_mark    <= long_seen_n;
			out_word_q.accurate_sync      <= acc_n;
			out_word_q.coarse_sync        <= crs_n;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_word_q;

	// ---------------- assertions ----------------
	`ASSERT_ALWAYS(a_stall_needs_word, clk, in_stall |-> valid_s1, "stall with empty input stage")
	`ASSERT_CLK(a_fire_gives_result, clk, arst_n, fire |=> out_valid_q, "event lost before result stage")
	`ASSERT_CLK(a_teeth_saturate, clk, arst_n, teeth_q <= TOOTH_SAT, "tooth counter above saturation")
	`ASSERT_CLK(a_cnt_wrap, clk, arst_n, (intake_cnt_q != 8'hFF) && (exhaust_cnt_q != 8'hFF), "edge counter reached 255")
	`ASSERT_CLK(a_acc_implies_crs, clk, arst_n, acc_q |-> crs_q, "accurate sync without coarse sync")

endmodule
